[design/dsc_pkg.sv]
// Package for the dictionary segmentation counter: widths, item kinds, states
// and the saturating add. No dependencies.
package dsc_pkg;
  localparam int MaxPatterns = 512;
  localparam int MaxPatternLen = 8;
  localparam int AddrW = $clog2(MaxPatterns);
  localparam int CountW = $clog2(MaxPatterns + 1);
  localparam int EntryW = 28;
  localparam int WaysW = 63;
  localparam int WinDepth = MaxPatternLen + 1;
  localparam int LenLimit = (MaxPatternLen < 8) ? MaxPatternLen : 8;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_SYM   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD_SCAN, ST_SYM_SCAN, ST_FINISH, ST_OUT
  } state_t;

  // control from the sequencer to the match logic; seen counts up to 128
  typedef struct packed {
    logic       start;
    logic       rd_valid;
    logic [7:0] seen;
  } cell_ctl_t;

  function automatic logic [WaysW:0] sat_add(input logic [WaysW-1:0] a,
                                              input logic [WaysW-1:0] b);
    logic [WaysW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[WaysW]) s = {1'b1, {WaysW{1'b1}}};
    return s;
  endfunction
endpackage

[design/dsc_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module dsc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

[design/dsc_cell.sv]
// One window cell: holds a symbol and a way count, passes them on one place
// per shift, and checks its own symbol against the streamed table entry.
// Depends on dsc_pkg.
module dsc_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clear,
  input  logic                     shift,
  input  logic [2:0]               sym_in,
  input  logic [dsc_pkg::WaysW-1:0] ways_in,
  input  logic [2:0]               entry_sym,
  input  logic                     match_in,
  output logic [2:0]               sym,
  output logic [dsc_pkg::WaysW-1:0] ways,
  output logic                     match_out
);
  import dsc_pkg::*;

  // compare the held symbol and AND with the upstream match chain
  assign match_out = match_in && (entry_sym == sym);

  // shift in the neighbor's values; clear to zero
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      sym  <= '0;
      ways <= '0;
    end else if (shift) begin
      sym  <= sym_in;
      ways <= ways_in;
    end
  end
endmodule

[design/dictionary_segmentation_counter.sv]
// Top level of the dictionary segmentation counter: sequencer, pattern RAM and
// the row of window cells. Depends on dsc_pkg, dsc_ram, dsc_cell.
//
//  channel | dir | fields
//  s_axis  | in  | tdata: pattern_symbols, pattern_length, symbol; tuser: kind;
//          |     | tlast: last_symbol
//  m_axis  | out | tdata: ways, possible, saturated, possible_total, ways_total
//
// Between the acceptance of a design symbol and the next acceptance the table is
// scanned at one entry per cycle from the registered RAM read, after the read
// pipeline is filled, and then the window shifts. A last symbol adds the ST_OUT
// state to load the result. A valid load scans the table for duplicates; clear,
// unused kinds and rejected loads leave the sequencer idle.
// Reset is synchronous and clears the count, window and totals. One item is
// in work at a time; a result holds in the output register until taken, and
// the next item is accepted meanwhile only once the result slot is free.
module dictionary_segmentation_counter (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [23:0] pattern_symbols, [27:24] pattern_length, [30:28] symbol, [31] zero
  input  logic [31:0]  s_tdata,
  // [1:0] kind
  input  logic [1:0]   s_tuser,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [62:0] ways, [63] possible, [64] saturated, [96:65] possible_total,
  // [159:97] ways_total, [167:160] zero
  output logic [167:0] m_tdata
);
  import dsc_pkg::*;

  localparam int L = MaxPatternLen;

  state_t state, state_next;
  logic [CountW-1:0] pat_count;
  logic [AddrW-1:0]  scan_idx;
  logic              rd_valid, rd_last, scan_done;
  logic [EntryW-1:0] cand;
  logic              dup;
  logic [2:0]        cur_sym;
  logic              cur_last;
  logic [WaysW-1:0]  acc;
  logic [6:0]        pos;
  logic [31:0]       poss_cnt;
  logic [WaysW-1:0]  ways_sum;
  logic              sat_seen;
  logic [WaysW-1:0]  res_ways;
  logic              res_poss;
  logic              out_valid;

  logic [WaysW-1:0] w_ways [WinDepth];
  logic [L:0]       mch;
  logic [EntryW-1:0] rdata;
  logic             ram_we;
  logic [AddrW-1:0] ram_addr;
  logic             acc_en, win_shift, win_clear;
  cell_ctl_t        ctl;

  logic [3:0]  in_len;
  logic [23:0] in_syms;
  logic [23:0] sym_mask;
  logic        in_ok;
  logic        accept;

  assign in_len  = s_tdata[27:24];
  assign accept  = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE) && !out_valid;

  // mask unused pattern symbol bits
  always_comb begin
    sym_mask = '0;
    for (int i = 0; i < 8; i++)
      if (i < int'(in_len)) sym_mask[3*i +: 3] = 3'b111;
    in_syms = s_tdata[23:0] & sym_mask;
  end
  assign in_ok = (in_len != 4'd0) && (int'(in_len) <= LenLimit) &&
                 (int'(pat_count) < MaxPatterns);

  // write at the end of the scan unless any entry, the last one included, matched
  assign ram_we   = (state == ST_LOAD_SCAN) && scan_done && !dup &&
                    !(rd_valid && rdata == cand);
  assign ram_addr = ram_we ? pat_count[AddrW-1:0] : scan_idx;

  dsc_ram #(.Width(EntryW), .Depth(MaxPatterns)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(cand), .rdata(rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:
        if (accept) begin
          if (s_tuser == KIND_LOAD && in_ok) state_next = ST_LOAD_SCAN;
          else if (s_tuser == KIND_SYM) state_next = ST_SYM_SCAN;
        end
      ST_LOAD_SCAN: if (scan_done) state_next = ST_IDLE;
      ST_SYM_SCAN:  if (scan_done) state_next = ST_FINISH;
      ST_FINISH:    state_next = cur_last ? ST_OUT : ST_IDLE;
      ST_OUT:       state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    acc_en    = (state == ST_SYM_SCAN) && rd_valid;
    win_shift = (state == ST_FINISH);
    win_clear = (state == ST_OUT) || (accept && s_tuser == KIND_CLEAR);
    ctl.start    = accept;
    ctl.rd_valid = rd_valid;
    ctl.seen     = {1'b0, pos} + 8'd1;
  end

  // the scan ends when the last address's data arrives, or when the table is empty
  assign scan_done = (pat_count == '0) || (rd_valid && rd_last);

  // advance the table scan
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      scan_idx <= '0;
      rd_valid <= 1'b0;
      rd_last <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        scan_idx <= '0;
        rd_valid <= 1'b0;
        rd_last <= 1'b0;
      end else if ((state == ST_LOAD_SCAN || state == ST_SYM_SCAN) && !scan_done) begin
        rd_valid <= (rd_valid && rd_last) ? 1'b0 : 1'b1;
        rd_last  <= (CountW'(scan_idx) + 1'b1 == pat_count);
        if (CountW'(scan_idx) + 1'b1 != pat_count) scan_idx <= scan_idx + 1'b1;
      end else begin
        rd_valid <= 1'b0;
      end
    end
  end

  // hold the current item
  always_ff @(posedge clk) begin
    if (accept) begin
      cand     <= {in_len, in_syms};
      cur_sym  <= s_tdata[30:28];
      cur_last <= s_tlast;
    end
  end

  // chain of cells: the incoming symbol is compared at the head against the
  // last pattern symbol, and cell d, which holds the symbol d+1 back, compares
  // against pattern symbol len-2-d
  logic [3:0] e_len;
  assign e_len  = rdata[27:24];
  assign mch[0] = (e_len == 4'd0) || (rdata[3*(int'(e_len)-1) +: 3] == cur_sym);
  logic [2:0] w_held [L];
  genvar g;
  for (g = 0; g < L; g++) begin : g_cell
    logic [2:0] esym;
    logic       m_in;
    assign esym = (g + 1 < int'(e_len)) ? rdata[3*(int'(e_len)-2-g) +: 3] : 3'd0;
    // cells beyond the pattern pass the chain through
    assign m_in = mch[g];
    logic mo;
    dsc_cell u_cell (
      .clk(clk), .rst(rst), .clear(win_clear), .shift(win_shift),
      .sym_in(g == 0 ? cur_sym : w_held[(g == 0) ? 0 : g-1]),
      .ways_in(w_ways[g]),
      .entry_sym(esym), .match_in(m_in),
      .sym(w_held[g]), .ways(w_ways[g+1]), .match_out(mo)
    );
    assign mch[g+1] = (g + 1 < int'(e_len)) ? mo : mch[g];
  end

  // ways for the entry: window count len-1 back (origin is w_ways[0])
  logic [WaysW-1:0] pick;
  logic             hit;
  always_comb begin
    pick = '0;
    for (int d = 0; d < WinDepth; d++)
      if (d == int'(e_len) - 1) pick = w_ways[d];
    hit = ctl.rd_valid && (e_len != 0) && (int'(e_len) <= LenLimit) &&
          (8'(e_len) <= ctl.seen) && mch[L];
  end

  logic [WaysW:0] acc_sum, tot_sum;
  assign acc_sum = sat_add(acc, pick);
  assign tot_sum = sat_add(ways_sum, acc);

  // origin cell of the ways window holds one after a restart
  always_ff @(posedge clk) begin
    if (rst || win_clear) w_ways[0] <= {{(WaysW-1){1'b0}}, 1'b1};
    else if (win_shift) w_ways[0] <= acc;
  end

  // accumulate, update totals and the result
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_count <= '0;
      pos <= '0;
      poss_cnt <= '0;
      ways_sum <= '0;
      sat_seen <= 1'b0;
      out_valid <= 1'b0;
      acc <= '0;
    end else begin
      if (ctl.start) acc <= '0;
      else if (acc_en && hit) begin
        acc <= acc_sum[WaysW-1:0];
        if (acc_sum[WaysW]) sat_seen <= 1'b1;
      end
      if (accept && s_tuser == KIND_CLEAR) begin
        pat_count <= '0;
        poss_cnt <= '0;
        ways_sum <= '0;
        sat_seen <= 1'b0;
        pos <= '0;
      end
      if ((state == ST_LOAD_SCAN) && rd_valid && rdata == cand) dup <= 1'b1;
      if (ram_we) pat_count <= pat_count + 1'b1;
      if (state == ST_FINISH) begin
        if (pos != 7'd127) pos <= pos + 7'd1;
        if (cur_last) begin
          res_ways <= acc;
          res_poss <= (acc != '0);
          if (acc != '0) begin
            if (poss_cnt != '1) poss_cnt <= poss_cnt + 1'b1;
            if (poss_cnt == '1 || tot_sum[WaysW]) sat_seen <= 1'b1;
            ways_sum <= tot_sum[WaysW-1:0];
          end
        end
      end
      if (state == ST_OUT) begin
        pos <= '0;
        out_valid <= 1'b1;
      end else if (m_tvalid && m_tready) out_valid <= 1'b0;
    end
    if (accept) dup <= 1'b0;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {8'd0, ways_sum, poss_cnt, sat_seen, res_poss, res_ways};

`ifndef SYNTHESIS
  // no input is taken while a result waits
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !s_tready) else $error("accept while result pending");
  // the table never exceeds its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(pat_count) <= MaxPatterns) else $error("pattern count overflow");
  // a result appears only after the finishing step of a last symbol
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_OUT)) else $error("spurious result");
`endif
endmodule
